/* rtl/ir_remote_command_frame_encoder_top_defines.svh */
// ----------------------------------------------------------------------------
// IR remote command frame encoder: assertion macros
// Shared property macros, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef IR_REMOTE_COMMAND_FRAME_ENCODER_TOP_DEFINES_SVH
`define IR_REMOTE_COMMAND_FRAME_ENCODER_TOP_DEFINES_SVH

// same-cycle implication
`define IRCFE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IRCFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ircfe_pkg.sv */
// ----------------------------------------------------------------------------
// ircfe_pkg
// Types and constants shared by the IR remote command frame encoder.
// ----------------------------------------------------------------------------
package ircfe_pkg;

    // command codes
    localparam logic [2:0] CMD_COMBO_DIRECT  = 3'd0;
    localparam logic [2:0] CMD_COMBO_PWM     = 3'd1;
    localparam logic [2:0] CMD_PIN_TIMEOUT   = 3'd2;
    localparam logic [2:0] CMD_PIN_CONTINUOUS = 3'd3;
    localparam logic [2:0] CMD_RAW_WORD      = 3'd4;

    // mode field codes placed in bits 10..8
    localparam logic [2:0] DIRECT_MODE_CODE     = 3'd1;
    localparam logic [2:0] TIMEOUT_MODE_CODE    = 3'd3;
    localparam logic [2:0] CONTINUOUS_MODE_CODE = 3'd2;

    // frame constants
    localparam logic [7:0] FRAME_START_BYTE = 8'h80;
    localparam logic [7:0] FRAME_FLAG_BYTE  = 8'h01;
    localparam int         WORD_BITS        = 16;

    // register map
    localparam logic REG_TX_MODE = 1'b0;

    // word queue depth between front and back (2 or more)
    localparam int IRCFE_QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [1:0]  channel;
        logic [3:0]  direct_bits;
        logic [3:0]  motor_a_pwm;
        logic [3:0]  motor_b_pwm;
        logic        output_sel;
        logic        pin_sel;
        logic [1:0]  pin_function;
        logic [15:0] raw_word;
    } cmd_item_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic [3:0] byte_index;
        logic       last;
    } frame_beat_t;

    // word handed from front to queue
    typedef struct packed {
        logic        valid;
        logic [15:0] word;
    } word_wr_t;

endpackage

/* rtl/ircfe_front.sv */
// ----------------------------------------------------------------------------
// ircfe_front
// Takes command beats, builds the 16-bit command word with toggle and checksum.
// ----------------------------------------------------------------------------
module ircfe_front
    import ircfe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  cmd_item_t item,
    output word_wr_t  wr
);

    logic toggle_reg;
    logic toggle_next;
    logic uses_toggle;
    logic known_cmd;
    logic [15:0] base_word;
    logic [3:0]  check;

    // word assembly by command kind
    always_comb
    begin
        uses_toggle = 1'b0;
        known_cmd   = 1'b1;
        base_word   = '0;
        case (item.cmd)
            CMD_COMBO_DIRECT:
            begin
                uses_toggle = 1'b1;
                base_word = {toggle_reg, 1'b0, item.channel, 1'b0, DIRECT_MODE_CODE,
                             item.direct_bits, 4'h0};
            end
            CMD_COMBO_PWM:
            begin
                base_word = {2'b01, item.channel, item.motor_b_pwm, item.motor_a_pwm, 4'h0};
            end
            CMD_PIN_TIMEOUT:
            begin
                uses_toggle = 1'b1;
                base_word = {toggle_reg, 1'b0, item.channel, 1'b0, TIMEOUT_MODE_CODE,
                             item.output_sel, item.pin_sel, item.pin_function, 4'h0};
            end
            CMD_PIN_CONTINUOUS:
            begin
                uses_toggle = 1'b1;
                base_word = {toggle_reg, 1'b0, item.channel, 1'b0, CONTINUOUS_MODE_CODE,
                             item.output_sel, item.pin_sel, item.pin_function, 4'h0};
            end
            CMD_RAW_WORD:
            begin
                base_word = item.raw_word;
            end
            default:
            begin
                known_cmd = 1'b0;
            end
        endcase
    end

    // nibble checksum; raw words pass as they are
    assign check = 4'hF ^ base_word[15:12] ^ base_word[11:8] ^ base_word[7:4];

    always_comb
    begin
        wr.valid = accept && known_cmd;
        if (item.cmd == CMD_RAW_WORD)
        begin
            wr.word = base_word;
        end
        else
        begin
            wr.word = {base_word[15:4], check};
        end
    end

    // toggle flips on each accepted toggled command
    assign toggle_next = (accept && uses_toggle) ? ~toggle_reg : toggle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            toggle_reg <= 1'b0;
        end
        else
        begin
            toggle_reg <= toggle_next;
        end
    end

endmodule

/* rtl/ircfe_wq.sv */
// ----------------------------------------------------------------------------
// ircfe_wq
// Short word queue between the command front and the frame serializer.
// ----------------------------------------------------------------------------
module ircfe_wq
    import ircfe_pkg::*;
#(
    parameter int DEPTH = IRCFE_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  word_wr_t    wr,
    input  logic        rd,
    output logic        full,
    output logic        nonempty,
    output logic [15:0] rd_word
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [15:0] words [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic do_wr;
    logic do_rd;

    assign full     = (count_reg == CNT_FULL);
    assign nonempty = (count_reg != '0);
    assign do_wr    = wr.valid && !full;
    assign do_rd    = rd && nonempty;
    assign rd_word  = words[rptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_wr)
        begin
            wptr_next = (wptr_reg == PTR_LAST) ? '0 : wptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rptr_next = (rptr_reg == PTR_LAST) ? '0 : rptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            words[wptr_reg] <= wr.word;
        end
    end

endmodule

/* rtl/ircfe_back.sv */
// ----------------------------------------------------------------------------
// ircfe_back
// Pulse-distance frame serializer: one frame byte per cycle while pop keeps up,
// into an output register.
// ----------------------------------------------------------------------------
module ircfe_back
    import ircfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        word_valid,
    input  logic [15:0] word_in,
    output logic        word_take,
    input  logic [7:0]  tx_mode,
    input  logic        pop,
    output logic        empty,
    output frame_beat_t result
);

    typedef enum logic [4:0] {
        PH_START = 5'b00001,
        PH_DATA  = 5'b00010,
        PH_LEN   = 5'b00100,
        PH_MODE  = 5'b01000,
        PH_FLAG  = 5'b10000
    } phase_t;

    phase_t state_reg, state_next;
    logic [15:0] word_reg, word_next;
    logic [4:0]  bits_reg, bits_next;
    logic [2:0]  gap_reg, gap_next;
    logic [3:0]  idx_reg, idx_next;
    logic        out_valid_reg, out_valid_next;
    frame_beat_t out_reg, out_next;

    logic        advance;
    logic        emit;
    logic [7:0]  data_byte;
    logic [15:0] data_word;
    logic [4:0]  data_bits;
    logic [2:0]  data_gap;
    logic        data_stop;

    assign advance = !out_valid_reg || pop;
    assign empty   = !out_valid_reg;
    assign result  = out_reg;

    // eight bit slots of the stream: marks, gaps, then one stop mark
    always_comb
    begin
        logic [15:0] w;
        logic [4:0]  b;
        logic [2:0]  g;
        logic        s;
        logic [7:0]  d;
        w = word_reg;
        b = bits_reg;
        g = gap_reg;
        s = 1'b0;
        d = '0;
        for (int k = 0; k < 8; k++)
        begin
            if (g != 3'd0)
            begin
                g = g - 3'd1;
            end
            else if (b != 5'd0)
            begin
                d[3'(7 - k)] = 1'b1;
                g = w[15] ? 3'd4 : 3'd2;
                w = {w[14:0], 1'b0};
                b = b - 5'd1;
            end
            else if (!s)
            begin
                d[3'(7 - k)] = 1'b1;
                s = 1'b1;
            end
        end
        data_byte = d;
        data_word = w;
        data_bits = b;
        data_gap  = g;
        data_stop = s;
    end

    // frame sequencer
    always_comb
    begin
        state_next = state_reg;
        word_next  = word_reg;
        bits_next  = bits_reg;
        gap_next   = gap_reg;
        idx_next   = idx_reg;
        emit       = 1'b0;
        word_take  = 1'b0;
        out_next   = out_reg;
        case (state_reg)
            PH_START:
            begin
                if (word_valid && advance)
                begin
                    emit       = 1'b1;
                    word_take  = 1'b1;
                    out_next   = '{frame_byte: FRAME_START_BYTE, byte_index: 4'd0, last: 1'b0};
                    word_next  = word_in;
                    bits_next  = 5'(WORD_BITS);
                    gap_next   = 3'd0;
                    idx_next   = 4'd1;
                    state_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (advance)
                begin
                    emit      = 1'b1;
                    out_next  = '{frame_byte: data_byte, byte_index: idx_reg, last: 1'b0};
                    word_next = data_word;
                    bits_next = data_bits;
                    gap_next  = data_gap;
                    idx_next  = idx_reg + 4'd1;
                    if (data_stop)
                    begin
                        state_next = PH_LEN;
                    end
                end
            end
            PH_LEN:
            begin
                if (advance)
                begin
                    emit       = 1'b1;
                    out_next   = '{frame_byte: {4'h0, idx_reg}, byte_index: idx_reg, last: 1'b0};
                    idx_next   = idx_reg + 4'd1;
                    state_next = PH_MODE;
                end
            end
            PH_MODE:
            begin
                if (advance)
                begin
                    emit       = 1'b1;
                    out_next   = '{frame_byte: tx_mode, byte_index: idx_reg, last: 1'b0};
                    idx_next   = idx_reg + 4'd1;
                    state_next = PH_FLAG;
                end
            end
            PH_FLAG:
            begin
                if (advance)
                begin
                    emit       = 1'b1;
                    out_next   = '{frame_byte: FRAME_FLAG_BYTE, byte_index: idx_reg, last: 1'b1};
                    state_next = PH_START;
                end
            end
            default:
            begin
                state_next = PH_START;
            end
        endcase
    end

    // output register valid
    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= PH_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        bits_reg <= bits_next;
        gap_reg  <= gap_next;
        idx_reg  <= idx_next;
        out_reg  <= out_next;
    end

endmodule

/* rtl/ir_remote_command_frame_encoder_top.sv */
// ----------------------------------------------------------------------------
// ir_remote_command_frame_encoder_top
// Remote command to pulse-distance IR frame encoder with APB mode register.
// ----------------------------------------------------------------------------
// Each accepted command with a known code produces one frame of 11 to 15
// bytes (11 + number of one bits in the word / 4, rounded down), sent one
// byte per clock while pop keeps up. Commands go into a short word queue
// (QUEUE_DEPTH words), so push is taken while a frame is still going out;
// full rises only when the queue is full. Unknown command codes are taken
// and dropped without output.
// tx_mode sits at byte address 0 and should be written only while idle.
module ir_remote_command_frame_encoder_top
    import ircfe_pkg::*;
#(
    parameter int QUEUE_DEPTH = IRCFE_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  cmd_item_t   item,
    input  logic        pop,
    output logic        empty,
    output frame_beat_t result
);

    `include "ir_remote_command_frame_encoder_top_defines.svh"

    logic [7:0]  tx_mode_reg, tx_mode_next;
    logic        reg_hit;
    logic        accept;
    word_wr_t    front_wr;
    logic        q_nonempty;
    logic [15:0] q_word;
    logic        q_take;
    logic        beat_out;
    logic        first_beat;
    logic        last_beat;
    logic        mid_pop;
    logic        start_ok;
    logic        flag_ok;

    // configuration register
    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == REG_TX_MODE);
    assign prdata  = reg_hit ? {24'h0, tx_mode_reg} : 32'h0;

    always_comb
    begin
        tx_mode_next = tx_mode_reg;
        if (psel && penable && pwrite && reg_hit)
        begin
            tx_mode_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_mode_reg <= 8'h00;
        end
        else
        begin
            tx_mode_reg <= tx_mode_next;
        end
    end

    assign accept = push && !full;

    ircfe_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .wr     (front_wr)
    );

    ircfe_wq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_wq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (front_wr),
        .rd       (q_take),
        .full     (full),
        .nonempty (q_nonempty),
        .rd_word  (q_word)
    );

    ircfe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (q_nonempty),
        .word_in    (q_word),
        .word_take  (q_take),
        .tx_mode    (tx_mode_reg),
        .pop        (pop),
        .empty      (empty),
        .result     (result)
    );

    // beat conditions for the checks
    assign beat_out   = !empty;
    assign first_beat = beat_out && (result.byte_index == 4'd0);
    assign last_beat  = beat_out && result.last;
    assign mid_pop    = pop && beat_out && !result.last;
    assign start_ok   = (result.frame_byte == FRAME_START_BYTE) && !result.last;
    assign flag_ok    = (result.frame_byte == FRAME_FLAG_BYTE);

    // checks
    `IRCFE_ASSERT_SAME(a_last_is_flag, last_beat, flag_ok, "last beat is not the flag byte")
    `IRCFE_ASSERT_SAME(a_first_is_start, first_beat, start_ok, "frame lacks start byte")
    `IRCFE_ASSERT_NEXT(a_frame_unbroken, mid_pop, beat_out, "gap inside a frame")

endmodule

/* bench/ir_remote_command_frame_encoder_top_tb.sv */
// ----------------------------------------------------------------------------
// IR remote command frame encoder testbench
// Sends remote commands through the push/full side and compares every frame
// beat popped from the result side with a frame built by a local predictor
// of the toggle bit, checksum and pulse-distance layout. tx_mode is
// reprogrammed over APB between phases, and both sides stall at random.
// ----------------------------------------------------------------------------
module ir_remote_command_frame_encoder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ircfe_pkg::*;

    // codes the block takes and drops
    localparam logic [2:0] CMD_FIRST_UNDEFINED = 3'd5;
    localparam logic [2:0] CMD_LAST_UNDEFINED  = 3'd7;

    localparam logic [2:0] TX_MODE_ADDR = {REG_TX_MODE, 2'b00};

    localparam int DRAIN_CYCLES  = 48;    // two queued words plus one frame
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int QUIET_LIMIT   = 4000;  // cycles with no beat accepted
    localparam int MAX_REPORTED  = 10;

    // ------------------------------------------------------------------------
    // frame predictor and store of expected frame beats
    // ------------------------------------------------------------------------
    class frame_scoreboard;
        logic [7:0]  tx_mode;
        bit          toggle;
        frame_beat_t beats_due[$];
        int          errors;
        int          beats_checked;
        int          commands_framed;
        int          commands_dropped;

        function new();
            tx_mode          = 8'h00;
            toggle           = 1'b0;
            errors           = 0;
            beats_checked    = 0;
            commands_framed  = 0;
            commands_dropped = 0;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= MAX_REPORTED)
                $display("ERROR: %s", msg);
        endfunction

        function int pending();
            return beats_due.size();
        endfunction

        // accepted command: build word, encode frame, queue its beats
        function void note_command(cmd_item_t c);
            logic [15:0] w;
            logic [7:0]  fr [16];
            logic [3:0]  csum;
            int          bitpos;
            int          n;
            frame_beat_t b;

            w = 16'h0000;
            case (c.cmd)
                CMD_COMBO_DIRECT:
                begin
                    w = {toggle, 1'b0, c.channel, 1'b0, DIRECT_MODE_CODE,
                         c.direct_bits, 4'h0};
                    toggle = ~toggle;
                end
                CMD_COMBO_PWM:
                begin
                    w = {2'b01, c.channel, c.motor_b_pwm, c.motor_a_pwm, 4'h0};
                end
                CMD_PIN_TIMEOUT:
                begin
                    w = {toggle, 1'b0, c.channel, 1'b0, TIMEOUT_MODE_CODE,
                         c.output_sel, c.pin_sel, c.pin_function, 4'h0};
                    toggle = ~toggle;
                end
                CMD_PIN_CONTINUOUS:
                begin
                    w = {toggle, 1'b0, c.channel, 1'b0, CONTINUOUS_MODE_CODE,
                         c.output_sel, c.pin_sel, c.pin_function, 4'h0};
                    toggle = ~toggle;
                end
                CMD_RAW_WORD:
                begin
                    w = c.raw_word;
                end
                default:
                begin
                    commands_dropped++;
                    return;
                end
            endcase

            // nibble checksum on built words only
            if (c.cmd != CMD_RAW_WORD)
            begin
                csum   = 4'hF ^ w[15:12] ^ w[11:8] ^ w[7:4];
                w[3:0] = csum;
            end

            foreach (fr[k])
                fr[k] = 8'h00;
            fr[0] = FRAME_START_BYTE;

            // one mark per word bit, MSB first, then the stop mark
            bitpos = 8;
            for (int i = 0; i <= WORD_BITS; i++)
            begin
                fr[bitpos >> 3] = fr[bitpos >> 3] | (8'h80 >> (bitpos & 7));
                if (i < WORD_BITS)
                    bitpos += w[WORD_BITS - 1 - i] ? 5 : 3;
            end
            n = (bitpos >> 3) + 1;
            fr[n]     = 8'(n);
            fr[n + 1] = tx_mode;
            fr[n + 2] = FRAME_FLAG_BYTE;

            for (int i = 0; i < n + 3; i++)
            begin
                b.frame_byte = fr[i];
                b.byte_index = 4'(i);
                b.last       = (i == n + 2);
                beats_due.push_back(b);
            end
            commands_framed++;
        endfunction

        // popped beat against the oldest expected one
        function void check_beat(frame_beat_t got);
            frame_beat_t want;
            if (beats_due.size() == 0)
            begin
                flag($sformatf("unexpected beat: byte=%02h idx=%0d last=%0b",
                               got.frame_byte, got.byte_index, got.last));
                return;
            end
            want = beats_due.pop_front();
            beats_checked++;
            if (got.frame_byte !== want.frame_byte || got.byte_index !== want.byte_index ||
                got.last !== want.last)
                flag($sformatf({"beat %0d: expected byte=%02h idx=%0d last=%0b, ",
                                "got byte=%02h idx=%0d last=%0b"},
                               beats_checked, want.frame_byte, want.byte_index, want.last,
                               got.frame_byte, got.byte_index, got.last));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals and block
    // ------------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        push;
    logic        full;
    cmd_item_t   item;
    logic        pop;
    logic        empty;
    frame_beat_t result;

    frame_scoreboard sb;
    bit tx_idle_en;
    bit rx_idle_en;
    int holds_asked = 0;
    int holds_done = 0;
    int settings_used;
    int quiet_cycles = 0;

    ir_remote_command_frame_encoder_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .push    (push),
        .full    (full),
        .item    (item),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // driver tasks
    // ------------------------------------------------------------------------
    task automatic apb_access(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // wait for idle, write tx_mode, read it back
    task automatic set_tx_mode(input logic [7:0] mode);
        logic [31:0] rd;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        apb_access(1'b1, TX_MODE_ADDR, {24'h0, mode}, rd);
        sb.tx_mode = mode;
        settings_used++;
        apb_access(1'b0, TX_MODE_ADDR, 32'h0, rd);
        if (rd !== {24'h0, mode})
            sb.flag($sformatf("tx_mode readback: expected %08h, got %08h", {24'h0, mode}, rd));
    endtask

    // one command beat; push stays high into the next call unless a gap follows
    task automatic send_command(input cmd_item_t c);
        int gap;
        @(negedge clk);
        push <= 1'b1;
        item <= c;
        do
            @(posedge clk);
        while (full);
        sb.note_command(c);
        if (tx_idle_en && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 17);
            @(negedge clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic stop_pushing();
        @(negedge clk);
        push <= 1'b0;
    endtask

    function automatic cmd_item_t random_command();
        logic [63:0] r;
        cmd_item_t  c;
        r = {$urandom, $urandom};
        c = r[$bits(cmd_item_t) - 1:0];
        if ($urandom_range(0, 9) == 0)
            c.cmd = 3'($urandom_range(CMD_FIRST_UNDEFINED, CMD_LAST_UNDEFINED));
        else
            c.cmd = 3'($urandom_range(CMD_COMBO_DIRECT, CMD_RAW_WORD));
        return c;
    endfunction

    // field extremes, every command, dropped codes, toggle across drops
    task automatic run_directed();
        cmd_item_t c;
        for (int k = 0; k < 18; k++)
        begin
            c = random_command();
            case (k)
                0:  begin c.cmd = CMD_COMBO_DIRECT; c.channel = 2'd0; c.direct_bits = 4'h0; end
                1:  begin c.cmd = CMD_COMBO_DIRECT; c.channel = 2'd3; c.direct_bits = 4'hF; end
                2:
                begin
                    c.cmd = CMD_COMBO_PWM; c.channel = 2'd0;
                    c.motor_a_pwm = 4'h0; c.motor_b_pwm = 4'h0;
                end
                3:
                begin
                    c.cmd = CMD_COMBO_PWM; c.channel = 2'd3;
                    c.motor_a_pwm = 4'hF; c.motor_b_pwm = 4'hF;
                end
                4:
                begin
                    c.cmd = CMD_COMBO_PWM; c.channel = 2'd1;
                    c.motor_a_pwm = 4'h5; c.motor_b_pwm = 4'hA;
                end
                5:
                begin
                    c.cmd = CMD_PIN_TIMEOUT; c.channel = 2'd1;
                    c.output_sel = 1'b1; c.pin_sel = 1'b1; c.pin_function = 2'd3;
                end
                6:
                begin
                    c.cmd = CMD_PIN_TIMEOUT; c.channel = 2'd2;
                    c.output_sel = 1'b0; c.pin_sel = 1'b0; c.pin_function = 2'd0;
                end
                7:
                begin
                    c.cmd = CMD_PIN_CONTINUOUS; c.channel = 2'd3;
                    c.output_sel = 1'b1; c.pin_sel = 1'b0; c.pin_function = 2'd2;
                end
                8:
                begin
                    c.cmd = CMD_PIN_CONTINUOUS; c.channel = 2'd0;
                    c.output_sel = 1'b0; c.pin_sel = 1'b1; c.pin_function = 2'd1;
                end
                9:  begin c.cmd = CMD_RAW_WORD; c.raw_word = 16'h0000; end  // shortest frame
                10: begin c.cmd = CMD_RAW_WORD; c.raw_word = 16'hFFFF; end  // longest frame
                11: begin c.cmd = CMD_RAW_WORD; c.raw_word = 16'hAAAA; end
                12: begin c.cmd = CMD_RAW_WORD; c.raw_word = 16'h5555; end
                13: c.cmd = CMD_FIRST_UNDEFINED;
                14: c.cmd = CMD_FIRST_UNDEFINED + 3'd1;
                15: c.cmd = CMD_LAST_UNDEFINED;
                // toggle must not have moved over the dropped codes
                16: begin c.cmd = CMD_COMBO_DIRECT; c.channel = 2'd2; c.direct_bits = 4'h9; end
                default: begin c.cmd = CMD_RAW_WORD; c.raw_word = 16'h8001; end
            endcase
            send_command(c);
        end
        stop_pushing();
    endtask

    // random commands until count framed ones are sent
    task automatic run_random(input int count);
        cmd_item_t c;
        int        framed;
        framed = 0;
        while (framed < count)
        begin
            c = random_command();
            send_command(c);
            if (c.cmd <= CMD_RAW_WORD)
                framed++;
        end
        stop_pushing();
    endtask

    // ------------------------------------------------------------------------
    // receiver: random stall bursts and the long hold-off
    // ------------------------------------------------------------------------
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        pop        = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_asked > holds_done)
            begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (rx_idle_en && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 17) - 1;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // result check and watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                sb.check_beat(result);
            if ((pop && !empty) || (push && !full))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no beat accepted for %0d cycles", QUIET_LIMIT);
                $display("ir_remote_command_frame_encoder_top: mismatch");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        sb            = new();
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        push          = 1'b0;
        item          = '0;
        tx_idle_en    = 1'b1;
        rx_idle_en    = 1'b1;
        settings_used = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_tx_mode(8'h00);
        run_directed();

        // receiver holds off while commands keep coming, so full must rise
        set_tx_mode(8'hFF);
        holds_asked++;
        run_random(30);

        set_tx_mode(8'($urandom_range(1, 254)));
        run_random(30);

        // closing stretch at full rate on both sides
        set_tx_mode(8'($urandom));
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        run_random(22);

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d framed and %0d dropped commands, %0d frame beats checked",
                 sb.commands_framed, sb.commands_dropped, sb.beats_checked);
        $display("over %0d tx_mode settings with %0d long receiver hold-off(s)",
                 settings_used, holds_done);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ir_remote_command_frame_encoder_top: match");
        else
            $display("ir_remote_command_frame_encoder_top: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/ircfe_pkg.sv
rtl/ircfe_front.sv
rtl/ircfe_wq.sv
rtl/ircfe_back.sv
rtl/ir_remote_command_frame_encoder_top.sv
bench/ir_remote_command_frame_encoder_top_tb.sv
